/* rtl/xsbr_pkg.sv */
// ----------------------------------------------------------------------------
// xsbr_pkg
// shared types and constants of the xorshift128 bounded random core
// ----------------------------------------------------------------------------
package xsbr_pkg;

  // request codes; the unused code behaves as a raw word
  localparam logic [1:0] ActRaw   = 2'd0;
  localparam logic [1:0] ActMod   = 2'd1;
  localparam logic [1:0] ActRange = 2'd2;

  // seed chain and xorshift constants
  localparam logic [31:0] SeedMult  = 32'd1812433253;
  localparam int unsigned SeedShift = 30;
  localparam int unsigned ShiftA    = 11;
  localparam int unsigned ShiftB    = 19;
  localparam int unsigned ShiftC    = 8;

  // sequencing
  localparam int unsigned SeedSteps = 4;
  localparam int unsigned DivSteps  = 32;
  localparam int unsigned SeedIdxW  = $clog2(SeedSteps);
  localparam int unsigned CntW      = $clog2(DivSteps);

  typedef enum logic [2:0] {
    ST_SEED,
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic                seed_step;
    logic [SeedIdxW-1:0] seed_idx;
    logic                accept;
    logic                div_step;
    logic                out_load;
  } cmd_t;

  typedef struct packed {
    logic needs_div;
  } status_t;

endpackage

/* rtl/xsbr_ctrl.sv */
// ----------------------------------------------------------------------------
// xsbr_ctrl
// sequencer for seeding, request acceptance, remainder steps and output
// ----------------------------------------------------------------------------
module xsbr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  xsbr_pkg::status_t status_i,
  output xsbr_pkg::cmd_t    cmd_o
);

  localparam logic [xsbr_pkg::CntW-1:0] SeedLast =
    xsbr_pkg::CntW'(xsbr_pkg::SeedSteps - 1);
  localparam logic [xsbr_pkg::CntW-1:0] DivLast =
    xsbr_pkg::CntW'(xsbr_pkg::DivSteps - 1);

  xsbr_pkg::state_e          state_q, state_d;
  logic [xsbr_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                      out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= xsbr_pkg::ST_SEED;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.seed_idx = cnt_q[xsbr_pkg::SeedIdxW-1:0];

    case (state_q)
      xsbr_pkg::ST_SEED: begin
        cmd_o.seed_step = 1'b1;
        if (cnt_q == SeedLast) begin
          cnt_d   = '0;
          state_d = xsbr_pkg::ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      xsbr_pkg::ST_IDLE: begin
        in_ready_o = !cfg_we_i;
        if (in_valid_i && !cfg_we_i) begin
          cmd_o.accept = 1'b1;
          state_d      = xsbr_pkg::ST_PREP;
        end
      end
      xsbr_pkg::ST_PREP: begin
        cnt_d = '0;
        if (status_i.needs_div) begin
          state_d = xsbr_pkg::ST_DIV;
        end else begin
          state_d = xsbr_pkg::ST_FIN;
        end
      end
      xsbr_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == DivLast) begin
          cnt_d   = '0;
          state_d = xsbr_pkg::ST_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      xsbr_pkg::ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = xsbr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = xsbr_pkg::ST_IDLE;
      end
    endcase

    // a seed write restarts the seed chain
    if (cfg_we_i) begin
      cmd_o.seed_step = 1'b0;
      cnt_d           = '0;
      state_d         = xsbr_pkg::ST_SEED;
    end
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/xsbr_datapath.sv */
// ----------------------------------------------------------------------------
// xsbr_datapath
// generator state, seed chain, restoring remainder unit and result register
// ----------------------------------------------------------------------------
module xsbr_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic [1:0]          action_i,
  input  logic signed [31:0]  bound_low_i,
  input  logic signed [31:0]  bound_high_i,
  input  xsbr_pkg::cmd_t      cmd_i,
  output xsbr_pkg::status_t   status_o,
  output logic signed [31:0]  value_o,
  output logic                zero_modulus_o
);

  logic [31:0] seed_q;
  logic [31:0] chain_q;
  logic [31:0] x_q, y_q, z_q, w_q;
  logic [31:0] word_q, dividend_q, rem_q, m_q, lo_q;
  logic [1:0]  action_q;
  logic [31:0] value_q;
  logic        zero_q;

  logic [31:0] seed_in, seed_mix, seed_next;
  logic [31:0] t_word, w_next;
  logic [31:0] lo_u, hi_u;
  logic [32:0] trial, diff;
  logic        bounded, mod_zero;

  // seed register, reset to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_we_i) begin
      seed_q <= cfg_wdata_i;
    end
  end

  // one link of the seed chain per cycle
  always_comb begin
    seed_in   = (cmd_i.seed_idx == '0) ? seed_q : chain_q;
    seed_mix  = seed_in ^ (seed_in >> xsbr_pkg::SeedShift);
    seed_next = xsbr_pkg::SeedMult * seed_mix
              + {{(32-xsbr_pkg::SeedIdxW){1'b0}}, cmd_i.seed_idx} + 32'd1;
  end

  // one xorshift128 advance
  always_comb begin
    t_word = x_q ^ (x_q << xsbr_pkg::ShiftA);
    w_next = (w_q ^ (w_q >> xsbr_pkg::ShiftB)) ^ (t_word ^ (t_word >> xsbr_pkg::ShiftC));
  end

  assign lo_u = $unsigned(bound_low_i);
  assign hi_u = $unsigned(bound_high_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.seed_step) begin
      chain_q <= seed_next;
      case (cmd_i.seed_idx)
        2'd0:    x_q <= seed_next;
        2'd1:    y_q <= seed_next;
        2'd2:    z_q <= seed_next;
        default: w_q <= seed_next;
      endcase
    end else if (cmd_i.accept) begin
      x_q <= y_q;
      y_q <= z_q;
      z_q <= w_q;
      w_q <= w_next;
    end
  end

  // request capture and remainder iteration
  assign trial = {rem_q, dividend_q[31]};
  assign diff  = trial - {1'b0, m_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      word_q     <= w_next;
      dividend_q <= w_next;
      rem_q      <= '0;
      action_q   <= action_i;
      lo_q       <= lo_u;
      m_q        <= (action_i == xsbr_pkg::ActMod) ? hi_u : (hi_u - lo_u + 32'd1);
    end else if (cmd_i.div_step) begin
      dividend_q <= dividend_q << 1;
      rem_q      <= diff[32] ? trial[31:0] : diff[31:0];
    end
  end

  assign bounded  = action_q inside {xsbr_pkg::ActMod, xsbr_pkg::ActRange};
  assign mod_zero = (m_q == '0);
  assign status_o.needs_div = bounded && !mod_zero;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      zero_q <= bounded && mod_zero;
      if (!bounded) begin
        value_q <= word_q;
      end else if (mod_zero) begin
        value_q <= '0;
      end else if (action_q == xsbr_pkg::ActRange) begin
        value_q <= lo_q + rem_q;
      end else begin
        value_q <= rem_q;
      end
    end
  end

  assign value_o        = $signed(value_q);
  assign zero_modulus_o = zero_q;

endmodule

/* rtl/xorshift128_bounded_random_core.sv */
// ----------------------------------------------------------------------------
// xorshift128_bounded_random_core: a raw word or a zero modulus goes from accept
// through PREP and FIN to the result register; a bounded word also runs the 32
// remainder steps in DIV, one bit a cycle; a new request is taken only once the
// last result is loaded, and FIN holds while a result stalls; reset and each seed
// write run the seed chain through the seed multiplier with in_ready_o low
// ----------------------------------------------------------------------------
module xorshift128_bounded_random_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  // seed register
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  // request words
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic signed [31:0] bound_low_i,
  input  logic signed [31:0] bound_high_i,
  // result words
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] value_o,
  output logic               zero_modulus_o
);

  // command and status between sequencer and datapath
  xsbr_pkg::cmd_t    cmd;
  xsbr_pkg::status_t status;

  // sequencer: seed chain, request capture, remainder steps, output handoff
  xsbr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: generator words, seed multiplier, remainder unit, result word
  xsbr_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .action_i       (action_i),
    .bound_low_i    (bound_low_i),
    .bound_high_i   (bound_high_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .value_o        (value_o),
    .zero_modulus_o (zero_modulus_o)
  );

endmodule

/* rtl/xsbr_checker.sv */
// ----------------------------------------------------------------------------
// xsbr_assert_checker
// port level checks on the bounded random core
// ----------------------------------------------------------------------------
module xsbr_assert_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] value_o,
  input logic               zero_modulus_o
);

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted twice in a row");

  // a seed write holds off requests while the chain runs
  a_seed_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_o)
    else $error("request taken during seeding");

  // zero modulus always reports a zero word
  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_modulus_o) |-> (value_o == 32'sd0))
    else $error("zero modulus with nonzero value");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(value_o) && $stable(zero_modulus_o)))
    else $error("stalled result changed");

endmodule

bind xorshift128_bounded_random_core xsbr_assert_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .cfg_we_i       (cfg_we_i),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .value_o        (value_o),
  .zero_modulus_o (zero_modulus_o)
);
